### rtl/hstw_pkg.sv
// ----------------------------------------------------------------------------
// Hex string checker package
// Shared types, codes and constants for the hex string to word checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hstw_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountCap = 4'd9;

  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChNine = 8'h39;
  localparam logic [CharW-1:0] ChUpA  = 8'h41;
  localparam logic [CharW-1:0] ChUpF  = 8'h46;
  localparam logic [CharW-1:0] TenOff = 8'd10;

  localparam logic [CountW-1:0] Limit8  = 4'd2;
  localparam logic [CountW-1:0] Limit16 = 4'd4;
  localparam logic [CountW-1:0] Limit32 = 4'd8;

  localparam logic [ModeW-1:0] ModeW8    = 2'd0;
  localparam logic [ModeW-1:0] ModeW16   = 2'd1;
  localparam logic [ModeW-1:0] ModeW32   = 2'd2;
  localparam logic [ModeW-1:0] ModeUnkn  = 2'd3;

  localparam logic [StatW-1:0] StOk     = 2'd0;
  localparam logic [StatW-1:0] StFormat = 2'd1;
  localparam logic [StatW-1:0] StRange  = 2'd2;
  localparam logic [StatW-1:0] StMode   = 2'd3;

  localparam logic [CfgIdxW-1:0] RegWidthMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRangeMin  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRangeMax  = 2'd2;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [3:0] digit;
    logic       bad;
    logic       take;
    logic       ends;
  } char_beat_t;

  typedef struct packed {
    logic [ModeW-1:0] width_mode;
    logic [WordW-1:0] range_min;
    logic [WordW-1:0] range_max;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/hstw_front.sv
// ----------------------------------------------------------------------------
// Hex string checker front end
// Accepts character beats, decodes digits and registers the classified beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hstw_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [hstw_pkg::CharW-1:0]  char_code_i,
  input  wire logic                        end_of_string_i,
  input  wire logic                        is_empty_i,
  output logic                             beat_valid_o,
  output hstw_pkg::char_beat_t             beat_o,
  input  wire logic                        beat_ready_i
);

  logic                 valid_q, valid_d;
  hstw_pkg::char_beat_t beat_q, beat_d;
  logic                 ready;
  logic                 is_dec, is_hex;
  logic [hstw_pkg::CharW-1:0] dec_val, hex_val;

  assign ready      = !valid_q || beat_ready_i;
  assign in_stall_o = !ready;

  always_comb begin
    is_dec  = (char_code_i >= hstw_pkg::ChZero) && (char_code_i <= hstw_pkg::ChNine);
    is_hex  = (char_code_i >= hstw_pkg::ChUpA) && (char_code_i <= hstw_pkg::ChUpF);
    dec_val = char_code_i - hstw_pkg::ChZero;
    hex_val = char_code_i - hstw_pkg::ChUpA + hstw_pkg::TenOff;
    beat_d.digit = is_dec ? dec_val[3:0] : (is_hex ? hex_val[3:0] : 4'd0);
    beat_d.bad   = !(is_dec || is_hex);
    beat_d.take  = !is_empty_i;
    beat_d.ends  = end_of_string_i || is_empty_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (ready) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

### rtl/hstw_fifo.sv
// ----------------------------------------------------------------------------
// Hex string checker beat queue
// Short queue of classified beats between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hstw_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire hstw_pkg::char_beat_t push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output hstw_pkg::char_beat_t      pop_data_o
);

  hstw_pkg::char_beat_t          mem_q [hstw_pkg::QDepth];
  logic [hstw_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [hstw_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [hstw_pkg::QCntW-1:0]    count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == hstw_pkg::QCntW'(hstw_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == hstw_pkg::QPtrW'(hstw_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == hstw_pkg::QPtrW'(hstw_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/hstw_back.sv
// ----------------------------------------------------------------------------
// Hex string checker back end
// Accumulates digits, checks the finished string and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hstw_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hstw_pkg::cfg_t               cfg_i,
  input  wire logic                         beat_avail_i,
  input  wire hstw_pkg::char_beat_t         beat_i,
  output logic                              beat_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [hstw_pkg::StatW-1:0]        status_o,
  output logic [hstw_pkg::WordW-1:0]        value_o
);

  logic [hstw_pkg::WordW-1:0]  acc_q, acc_d, acc_n;
  logic [hstw_pkg::CountW-1:0] cnt_q, cnt_d, cnt_n;
  logic                        bad_q, bad_d, bad_n;
  logic                        out_valid_q, out_valid_d;
  logic [hstw_pkg::StatW-1:0]  status_q, status_d;
  logic [hstw_pkg::WordW-1:0]  value_q, value_d;
  logic [hstw_pkg::CountW-1:0] limit;
  logic                        out_free, pop, finish;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = beat_avail_i && (!beat_i.ends || out_free);
  assign finish     = pop && beat_i.ends;
  assign beat_pop_o = pop;

  always_comb begin
    acc_n = acc_q;
    bad_n = bad_q;
    cnt_n = cnt_q;
    if (beat_i.take) begin
      if (beat_i.bad) begin
        bad_n = 1'b1;
      end else begin
        acc_n = {acc_q[hstw_pkg::WordW-5:0], beat_i.digit};
      end
      if (cnt_q < hstw_pkg::CountCap) begin
        cnt_n = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cfg_i.width_mode)
      hstw_pkg::ModeW8:  limit = hstw_pkg::Limit8;
      hstw_pkg::ModeW16: limit = hstw_pkg::Limit16;
      default:           limit = hstw_pkg::Limit32;
    endcase
  end

  always_comb begin
    status_d = hstw_pkg::StOk;
    value_d  = '0;
    if (cfg_i.width_mode == hstw_pkg::ModeUnkn) begin
      status_d = hstw_pkg::StMode;
    end else if (cnt_n == '0 || cnt_n > limit || bad_n) begin
      status_d = hstw_pkg::StFormat;
    end else if (acc_n < cfg_i.range_min || acc_n > cfg_i.range_max) begin
      status_d = hstw_pkg::StRange;
    end else begin
      value_d = acc_n;
    end
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    bad_d = bad_q;
    if (pop) begin
      if (beat_i.ends) begin
        acc_d = '0;
        cnt_d = '0;
        bad_d = 1'b0;
      end else begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        bad_d = bad_n;
      end
    end
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;

endmodule

`default_nettype wire

### rtl/hex_string_to_word_checker.sv
// ----------------------------------------------------------------------------
// Hex string to word checker
// Decodes an ASCII hex string, one character per beat, and checks its width
// and range. The block takes one character beat per clock cycle, sustained
// while the output is not stalled, limited by the digit shift in the back end.
// A front register, a two-entry beat queue and a result register sit on the
// path, in that order, and one result can wait on a stalled output while the
// next string keeps streaming. The width mode and range registers are read
// when a string ends and should be written only while no string is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_string_to_word_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hstw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hstw_pkg::WordW-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [hstw_pkg::CharW-1:0]     char_code_i,
  input  wire logic                           end_of_string_i,
  input  wire logic                           is_empty_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [hstw_pkg::StatW-1:0]          status_o,
  output logic [hstw_pkg::WordW-1:0]          value_o
);

  hstw_pkg::cfg_t       cfg_q, cfg_d;
  logic                 front_valid;
  hstw_pkg::char_beat_t front_beat;
  logic                 q_full, q_empty, q_pop;
  hstw_pkg::char_beat_t q_beat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hstw_pkg::RegWidthMode: cfg_d.width_mode = cfg_wdata_i[hstw_pkg::ModeW-1:0];
        hstw_pkg::RegRangeMin:  cfg_d.range_min  = cfg_wdata_i;
        hstw_pkg::RegRangeMax:  cfg_d.range_max  = cfg_wdata_i;
        default:                cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_mode <= hstw_pkg::ModeW32;
      cfg_q.range_min  <= '0;
      cfg_q.range_max  <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hstw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .is_empty_i      (is_empty_i),
    .beat_valid_o    (front_valid),
    .beat_o          (front_beat),
    .beat_ready_i    (!q_full)
  );

  hstw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_beat),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_beat)
  );

  hstw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .beat_avail_i (!q_empty),
    .beat_i       (q_beat),
    .beat_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .value_o      (value_o)
  );

endmodule

`default_nettype wire
